[rtl/cdrs_pkg.sv]
// ----------------------------------------------------------------------------
// cdrs_pkg: shared types and codes of the C-SCAN disk request scheduler
// Holds the item kind and the result status codes.
// ----------------------------------------------------------------------------
package cdrs_pkg;

    // Kind of an input item, as carried on the slave tuser bit
    typedef enum logic
    {
        KIND_REQUEST = 1'b0,
        KIND_RELEASE = 1'b1
    } op_t;

    // Result status
    typedef logic [1:0] status_t;

    localparam status_t ST_OK          = 2'd0;
    localparam status_t ST_FULL        = 2'd1;
    localparam status_t ST_IDLE_RELEASE = 2'd2;

endpackage

[rtl/cscan_disk_request_scheduler.sv]
// ----------------------------------------------------------------------------
// cscan_disk_request_scheduler: C-SCAN disk request scheduler
// Grants one disk to requesters in C-SCAN track order, parking waiting
// requests in a slot table and sweeping it on each release that finds them.
// ----------------------------------------------------------------------------
//  channel  direction  tdata (low bit up)                tuser (low bit up)
//  s_*      in         req_id, req_track                 op (0 request, 1 release)
//  m_*      out        grant_id, grant_track, disk_busy  grant_valid, status
//
//  Order: one item is worked at a time by the scan engine. Requests to an
//  idle disk, requests to a full table and releases that find no work go
//  straight to the result state; a queued request first walks the slots for
//  the lowest free one; a release with pending entries walks all slots of
//  the registered-read slot memory, one per cycle, for the minimum track.
//  Reset: rst_n clears the slot valid bits, busy flag and current track at
//  once; no clearing pass is needed. Stalls: the two-entry input queue still
//  takes up to two items while the engine works or a result waits on m_tready.
// ----------------------------------------------------------------------------
module cscan_disk_request_scheduler
    import cdrs_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int TRACK_BITS = 16,
    parameter int ID_BITS    = 8
) (
    input  logic clk,
    input  logic rst_n,
    // input items
    input  logic s_tvalid,
    output logic s_tready,
    // req_id, req_track
    input  logic [((ID_BITS + TRACK_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // op
    input  logic s_tuser,
    // result items
    output logic m_tvalid,
    input  logic m_tready,
    // grant_id, grant_track, disk_busy
    output logic [((ID_BITS + TRACK_BITS + 1 + 7) / 8) * 8 - 1:0] m_tdata,
    // grant_valid, status
    output logic [2:0] m_tuser
);

    localparam int OUT_W = ((ID_BITS + TRACK_BITS + 1 + 7) / 8) * 8;

    logic                  item_valid;
    logic                  item_ready;
    op_t                   item_kind;
    logic [ID_BITS-1:0]    item_id;
    logic [TRACK_BITS-1:0] item_track;
    logic                  res_grant;
    logic [ID_BITS-1:0]    res_id;
    logic [TRACK_BITS-1:0] res_track;
    logic                  res_busy;
    status_t               res_status;

    // accept and decode items into the queue
    cdrs_front #(
        .TRACK_BITS (TRACK_BITS),
        .ID_BITS    (ID_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tuser),
        .in_id      (s_tdata[ID_BITS-1:0]),
        .in_track   (s_tdata[ID_BITS+TRACK_BITS-1:ID_BITS]),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_kind  (item_kind),
        .item_id    (item_id),
        .item_track (item_track)
    );

    // slot table and sweep engine
    cdrs_back #(
        .SLOTS      (SLOTS),
        .TRACK_BITS (TRACK_BITS),
        .ID_BITS    (ID_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_kind  (item_kind),
        .item_id    (item_id),
        .item_track (item_track),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_grant  (res_grant),
        .res_id     (res_id),
        .res_track  (res_track),
        .res_busy   (res_busy),
        .res_status (res_status)
    );

    // pack result fields, zero fill to whole bytes
    assign m_tdata = OUT_W'({res_busy, res_track, res_id});
    assign m_tuser = {res_status, res_grant};

endmodule

[rtl/cdrs_ram.sv]
// ----------------------------------------------------------------------------
// cdrs_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cdrs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/cdrs_front.sv]
// ----------------------------------------------------------------------------
// cdrs_front: input side of the scheduler
// Accept items, decode the op into an item kind and hold them in a
// two-entry queue so the scan engine can stall on its own.
// ----------------------------------------------------------------------------
module cdrs_front
    import cdrs_pkg::*;
#(
    parameter int TRACK_BITS = 16,
    parameter int ID_BITS    = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_op,
    input  logic [ID_BITS-1:0]    in_id,
    input  logic [TRACK_BITS-1:0] in_track,
    // toward the back end
    output logic                  item_valid,
    input  logic                  item_ready,
    output op_t                   item_kind,
    output logic [ID_BITS-1:0]    item_id,
    output logic [TRACK_BITS-1:0] item_track
);

    localparam int ENTRY_W = 1 + ID_BITS + TRACK_BITS;

    logic [ENTRY_W-1:0] q_reg [2];
    logic [ENTRY_W-1:0] q_next [2];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic               push;
    logic               pop;
    logic [ENTRY_W-1:0] head;

    assign in_ready   = (cnt_reg != 2'd2);
    assign item_valid = (cnt_reg != 2'd0);
    assign push       = in_valid && in_ready;
    assign pop        = item_valid && item_ready;
    assign head       = q_reg[rd_ptr_reg];

    assign item_kind  = head[0] ? KIND_RELEASE : KIND_REQUEST;
    assign item_id    = head[ID_BITS:1];
    assign item_track = head[ENTRY_W-1:ID_BITS+1];

    always_comb
    begin
        q_next      = q_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            q_next[wr_ptr_reg] = {in_track, in_id, in_op};
            wr_ptr_next        = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        unique case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue payload carries no reset
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

endmodule

[rtl/cdrs_back.sv]
// ----------------------------------------------------------------------------
// cdrs_back: scan engine of the scheduler
// Hold the slot table, run one item at a time, scan slots one per cycle
// for the lowest free slot or the minimum eligible track, and drive the
// result register.
// ----------------------------------------------------------------------------
module cdrs_back
    import cdrs_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int TRACK_BITS = 16,
    parameter int ID_BITS    = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // from the front queue
    input  logic                  item_valid,
    output logic                  item_ready,
    input  op_t                   item_kind,
    input  logic [ID_BITS-1:0]    item_id,
    input  logic [TRACK_BITS-1:0] item_track,
    // result register
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic                  res_grant,
    output logic [ID_BITS-1:0]    res_id,
    output logic [TRACK_BITS-1:0] res_track,
    output logic                  res_busy,
    output status_t               res_status
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int MEM_W = ID_BITS + TRACK_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOTS);

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_FREE,
        S_MIN,
        S_RESULT
    } state_t;

    state_t                state_reg, state_next;
    // slot table flags and counts
    logic [SLOTS-1:0]      valid_reg, valid_next;
    logic [SLOTS-1:0]      upper_reg, upper_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [CNT_W-1:0]      upcnt_reg, upcnt_next;
    logic                  busy_reg, busy_next;
    logic [TRACK_BITS-1:0] cur_reg, cur_next;
    // item under work
    logic [ID_BITS-1:0]    id_reg, id_next;
    logic [TRACK_BITS-1:0] trk_reg, trk_next;
    // scan
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  issued_reg, issued_next;
    logic                  pend_reg, pend_next;
    logic                  pend_elig_reg, pend_elig_next;
    logic [IDX_W-1:0]      pend_idx_reg, pend_idx_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      best_idx_reg, best_idx_next;
    logic [TRACK_BITS-1:0] best_trk_reg, best_trk_next;
    logic [ID_BITS-1:0]    best_id_reg, best_id_next;
    // pending result
    logic                  pgv_reg, pgv_next;
    logic [ID_BITS-1:0]    pid_reg, pid_next;
    logic [TRACK_BITS-1:0] ptrk_reg, ptrk_next;
    status_t               pst_reg, pst_next;
    // output register
    logic                  ov_reg, ov_next;
    logic                  ogv_reg, ogv_next;
    logic [ID_BITS-1:0]    oid_reg, oid_next;
    logic [TRACK_BITS-1:0] otrk_reg, otrk_next;
    logic                  obusy_reg, obusy_next;
    status_t               ost_reg, ost_next;

    // slot payload memory
    logic                  wr_en;
    logic                  rd_en;
    logic [MEM_W-1:0]      rd_data;
    logic [TRACK_BITS-1:0] rd_trk;
    logic [ID_BITS-1:0]    rd_id;
    logic                  new_upper;

    assign rd_trk    = rd_data[TRACK_BITS-1:0];
    assign rd_id     = rd_data[MEM_W-1:TRACK_BITS];
    assign new_upper = (trk_reg >= cur_reg);

    cdrs_ram #(
        .WIDTH (MEM_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data ({id_reg, trk_reg}),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign item_ready = (state_reg == S_IDLE);
    assign res_valid  = ov_reg;
    assign res_grant  = ogv_reg;
    assign res_id     = oid_reg;
    assign res_track  = otrk_reg;
    assign res_busy   = obusy_reg;
    assign res_status = ost_reg;

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        upper_next     = upper_reg;
        cnt_next       = cnt_reg;
        upcnt_next     = upcnt_reg;
        busy_next      = busy_reg;
        cur_next       = cur_reg;
        id_next        = id_reg;
        trk_next       = trk_reg;
        idx_next       = idx_reg;
        issued_next    = issued_reg;
        pend_next      = 1'b0;
        pend_elig_next = pend_elig_reg;
        pend_idx_next  = pend_idx_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_trk_next  = best_trk_reg;
        best_id_next   = best_id_reg;
        pgv_next       = pgv_reg;
        pid_next       = pid_reg;
        ptrk_next      = ptrk_reg;
        pst_next       = pst_reg;
        ov_next        = ov_reg && !res_ready;
        ogv_next       = ogv_reg;
        oid_next       = oid_reg;
        otrk_next      = otrk_reg;
        obusy_next     = obusy_reg;
        ost_next       = ost_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    id_next     = item_id;
                    trk_next    = item_track;
                    idx_next    = '0;
                    issued_next = 1'b0;
                    found_next  = 1'b0;
                    pgv_next    = 1'b0;
                    pid_next    = '0;
                    ptrk_next   = '0;
                    pst_next    = ST_OK;
                    state_next  = S_RESULT;
                    if (item_kind == KIND_REQUEST)
                    begin
                        priority if (!busy_reg)
                        begin
                            // idle disk: grant at once
                            busy_next = 1'b1;
                            cur_next  = item_track;
                            pgv_next  = 1'b1;
                            pid_next  = item_id;
                            ptrk_next = item_track;
                        end
                        else if (cnt_reg == FULL_CNT)
                        begin
                            pst_next = ST_FULL;
                        end
                        else
                        begin
                            state_next = S_FREE;
                        end
                    end
                    else
                    begin
                        priority if (!busy_reg)
                        begin
                            pst_next = ST_IDLE_RELEASE;
                        end
                        else if (cnt_reg == '0)
                        begin
                            busy_next = 1'b0;
                        end
                        else
                        begin
                            // no upper entry left: wrap the sweep
                            if (upcnt_reg == '0)
                            begin
                                upper_next = upper_reg | valid_reg;
                                upcnt_next = cnt_reg;
                            end
                            state_next = S_MIN;
                        end
                    end
                end
            end

            S_FREE:
            begin
                if (!valid_reg[idx_reg])
                begin
                    wr_en               = 1'b1;
                    valid_next[idx_reg] = 1'b1;
                    upper_next[idx_reg] = new_upper;
                    cnt_next            = cnt_reg + CNT_W'(1);
                    upcnt_next          = upcnt_reg + CNT_W'(new_upper);
                    state_next          = S_RESULT;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_MIN:
            begin
                // issue one read per cycle
                if (!issued_reg)
                begin
                    rd_en          = 1'b1;
                    pend_next      = 1'b1;
                    pend_idx_next  = idx_reg;
                    pend_elig_next = valid_reg[idx_reg] && upper_reg[idx_reg];
                    if (idx_reg == LAST_IDX)
                    begin
                        issued_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
                // compare the slot read last cycle; strict less keeps lowest slot
                if (pend_reg && pend_elig_reg && (!found_reg || (rd_trk < best_trk_reg)))
                begin
                    found_next    = 1'b1;
                    best_idx_next = pend_idx_reg;
                    best_trk_next = rd_trk;
                    best_id_next  = rd_id;
                end
                if (issued_reg && !pend_reg)
                begin
                    valid_next[best_idx_reg] = 1'b0;
                    cnt_next   = cnt_reg - CNT_W'(1);
                    upcnt_next = upcnt_reg - CNT_W'(1);
                    cur_next   = best_trk_reg;
                    pgv_next   = 1'b1;
                    pid_next   = best_id_reg;
                    ptrk_next  = best_trk_reg;
                    state_next = S_RESULT;
                end
            end

            S_RESULT:
            begin
                if (!ov_reg || res_ready)
                begin
                    ov_next    = 1'b1;
                    ogv_next   = pgv_reg;
                    oid_next   = pid_reg;
                    otrk_next  = ptrk_reg;
                    obusy_next = busy_reg;
                    ost_next   = pst_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            upper_reg     <= '0;
            cnt_reg       <= '0;
            upcnt_reg     <= '0;
            busy_reg      <= 1'b0;
            cur_reg       <= '0;
            id_reg        <= '0;
            trk_reg       <= '0;
            idx_reg       <= '0;
            issued_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            pend_elig_reg <= 1'b0;
            pend_idx_reg  <= '0;
            found_reg     <= 1'b0;
            best_idx_reg  <= '0;
            best_trk_reg  <= '0;
            best_id_reg   <= '0;
            pgv_reg       <= 1'b0;
            pid_reg       <= '0;
            ptrk_reg      <= '0;
            pst_reg       <= ST_OK;
            ov_reg        <= 1'b0;
            ogv_reg       <= 1'b0;
            oid_reg       <= '0;
            otrk_reg      <= '0;
            obusy_reg     <= 1'b0;
            ost_reg       <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            upper_reg     <= upper_next;
            cnt_reg       <= cnt_next;
            upcnt_reg     <= upcnt_next;
            busy_reg      <= busy_next;
            cur_reg       <= cur_next;
            id_reg        <= id_next;
            trk_reg       <= trk_next;
            idx_reg       <= idx_next;
            issued_reg    <= issued_next;
            pend_reg      <= pend_next;
            pend_elig_reg <= pend_elig_next;
            pend_idx_reg  <= pend_idx_next;
            found_reg     <= found_next;
            best_idx_reg  <= best_idx_next;
            best_trk_reg  <= best_trk_next;
            best_id_reg   <= best_id_next;
            pgv_reg       <= pgv_next;
            pid_reg       <= pid_next;
            ptrk_reg      <= ptrk_next;
            pst_reg       <= pst_next;
            ov_reg        <= ov_next;
            ogv_reg       <= ogv_next;
            oid_reg       <= oid_next;
            otrk_reg      <= otrk_next;
            obusy_reg     <= obusy_next;
            ost_reg       <= ost_next;
        end
    end

`ifndef ASSERT_OFF
    a_cnt_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) == $countones(valid_reg))
        else $error("slot count out of step with valid bits");

    a_upcnt_matches_upper: assert property (@(posedge clk) disable iff (!rst_n)
        32'(upcnt_reg) == $countones(valid_reg & upper_reg))
        else $error("upper count out of step with upper bits");

    a_grant_keeps_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && ogv_reg) |-> obusy_reg)
        else $error("grant reported with idle disk");

    a_min_scan_finds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MIN && issued_reg && !pend_reg) |-> found_reg)
        else $error("release scan ended with no eligible slot");
`endif

endmodule
